// File: rtl/clmm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the cavity local maximum marker
// no dependencies

package clmm_pkg;

   localparam int MaxSize    = 32;
   localparam int ColW       = $clog2(MaxSize);
   localparam int GridW      = 6;
   localparam int DepthW     = 4;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);

   // one classified item on its way from front to back
   typedef struct packed {
      logic [DepthW-1:0] depth;
      logic [ColW-1:0]   col;
      logic              emit;
      logic              interior;
      logic              last;
   } cmd_type;

endpackage

// File: rtl/cavity_local_max_marker_top.sv
`timescale 1ns / 1ps
// top level of the cavity local maximum marker: front, queue and back
// depends on clmm_pkg, clmm_front, clmm_queue, clmm_back
// throughput: one item per cycle unless the result channel or a flush stalls it; a cell is offered
//   after the item one row and one cell later passes the queue, line store read and output register
// end of frame: the flush gives n+2 results (centre, cell to its right, whole last row); n of 1 gives one result
// reset: synchronous, clears counters, queue and pipeline; side length returns to 32

module cavity_local_max_marker_top import clmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_tvalid,
   output logic       csr_tready,
   input  logic [7:0] csr_tdata,   // grid_size [5:0]
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // depth_digit [3:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // cell_depth [3:0], is_cavity [4]
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // end_of_frame
);

   logic    f_push, f_ready, b_pop, b_valid;
   cmd_type f_cmd, b_cmd;

   clmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (f_push),
      .q_cmd      (f_cmd),
      .q_ready    (f_ready)
   );

   clmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_push),
      .push_cmd   (f_cmd),
      .push_ready (f_ready),
      .pop        (b_pop),
      .pop_valid  (b_valid),
      .pop_cmd    (b_cmd)
   );

   clmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (b_valid),
      .q_cmd      (b_cmd),
      .q_pop      (b_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: rtl/clmm_front.sv
`timescale 1ns / 1ps
// front end: size register, raster counters and item classification
// depends on clmm_pkg

module clmm_front import clmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_tvalid,
   output logic       csr_tready,
   input  logic [7:0] csr_tdata,   // grid_size [5:0]
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // depth_digit [3:0]
   output logic       q_push,
   output cmd_type    q_cmd,
   input  logic       q_ready
);

   logic [GridW-1:0] grid_ff;
   logic [GridW-1:0] side_len;
   logic [ColW-1:0]  last_idx;
   logic [ColW-1:0]  row_ff, row_in;
   logic [ColW-1:0]  col_ff, col_in;
   logic             is_last;

   assign csr_tready = 1'b1;
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      priority if (grid_ff == '0) begin
         side_len = GridW'(1);
      end else if (grid_ff > GridW'(MaxSize)) begin
         side_len = GridW'(MaxSize);
      end else begin
         side_len = grid_ff;
      end
   end

   assign last_idx = ColW'(side_len - GridW'(1));
   assign is_last  = (row_ff == last_idx) && (col_ff == last_idx);

   always_comb begin
      q_cmd.depth    = req_tdata[DepthW-1:0];
      q_cmd.col      = col_ff;
      q_cmd.last     = is_last;
      q_cmd.interior = (row_ff >= ColW'(2)) && (col_ff >= ColW'(2));
      q_cmd.emit     = (row_ff >= ColW'(2)) || ((row_ff == ColW'(1)) && (col_ff != '0));
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      priority if (csr_tvalid) begin
         row_in = '0;
         col_in = '0;
      end else if (q_push) begin
         priority if (is_last) begin
            row_in = '0;
            col_in = '0;
         end else if (col_ff == last_idx) begin
            row_in = row_ff + ColW'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff <= GridW'(MaxSize);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         if (csr_tvalid) begin
            grid_ff <= csr_tdata[GridW-1:0];
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

// File: rtl/clmm_queue.sv
`timescale 1ns / 1ps
// short command queue between front and back
// depends on clmm_pkg

module clmm_queue import clmm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type          entry_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff;
   logic [QPtrW-1:0] rd_ptr_ff;
   logic [QPtrW:0]   count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != (QPtrW+1)'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (QPtrW+1)'(1);
            2'b01:   count_ff <= count_ff - (QPtrW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/clmm_back.sv
`timescale 1ns / 1ps
// back end: line store, neighbour window, cavity test, frame flush, output register
// depends on clmm_pkg

module clmm_back import clmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // cell_depth [3:0], is_cavity [4]
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // end_of_frame
);

   typedef enum logic [1:0] {PH_MAIN, PH_RIGHT, PH_ROW} phase_type;

   // low nibble: row above the current one, high nibble: two rows above
   logic [2*DepthW-1:0] line_mem [MaxSize];

   phase_type           phase_ff, phase_in;
   logic                b_valid_ff;
   cmd_type             b_cmd_ff;
   logic [2*DepthW-1:0] b_rd_ff;
   logic [ColW-1:0]     ptr_ff, ptr_in;
   logic [DepthW-1:0]   fl_rd_ff;
   logic [DepthW-1:0]   up_ff, ctr_ff, left_ff, down_ff;
   logic                rsp_valid_ff;
   logic [DepthW-1:0]   rsp_depth_ff;
   logic                rsp_cav_ff, rsp_last_ff, rsp_eof_ff;

   logic                out_space, emit_now, done, cavity, row_final;
   logic [DepthW-1:0]   res_depth, right_d;
   logic                res_cav, res_last, res_eof;

   assign right_d   = b_rd_ff[DepthW-1:0];
   assign out_space = !rsp_valid_ff || rsp_tready;
   assign row_final = ptr_ff == b_cmd_ff.col;
   assign cavity    = b_cmd_ff.interior && (ctr_ff > up_ff) && (ctr_ff > down_ff) &&
                      (ctr_ff > left_ff) && (ctr_ff > right_d);

   always_comb begin
      emit_now  = 1'b0;
      done      = 1'b0;
      phase_in  = phase_ff;
      ptr_in    = ptr_ff;
      res_depth = ctr_ff;
      res_cav   = 1'b0;
      res_last  = 1'b0;
      res_eof   = 1'b0;
      if (b_valid_ff) begin
         unique case (phase_ff)
            PH_MAIN: begin
               if (b_cmd_ff.emit) begin
                  emit_now = 1'b1;
                  res_cav  = cavity;
                  res_last = !b_cmd_ff.last;
                  if (out_space) begin
                     if (b_cmd_ff.last) begin
                        phase_in = PH_RIGHT;
                     end else begin
                        done = 1'b1;
                     end
                  end
               end else if (b_cmd_ff.last) begin
                  phase_in = PH_ROW;
               end else begin
                  done = 1'b1;
               end
            end
            PH_RIGHT: begin
               emit_now  = 1'b1;
               res_depth = right_d;
               if (out_space) begin
                  phase_in = PH_ROW;
               end
            end
            PH_ROW: begin
               emit_now  = 1'b1;
               res_depth = row_final ? b_cmd_ff.depth : fl_rd_ff;
               res_last  = row_final;
               res_eof   = row_final;
               if (out_space) begin
                  if (row_final) begin
                     done     = 1'b1;
                     phase_in = PH_MAIN;
                     ptr_in   = '0;
                  end else begin
                     ptr_in = ptr_ff + ColW'(1);
                  end
               end
            end
            default: begin
               phase_in = PH_MAIN;
            end
         endcase
      end
   end

   assign q_pop = q_valid && (!b_valid_ff || done);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAIN;
         b_valid_ff   <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         up_ff        <= '0;
         ctr_ff       <= '0;
         left_ff      <= '0;
         down_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         ptr_ff   <= ptr_in;
         if (q_pop) begin
            b_valid_ff <= 1'b1;
         end else if (done) begin
            b_valid_ff <= 1'b0;
         end
         if (emit_now && out_space) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done) begin
            left_ff <= ctr_ff;
            ctr_ff  <= b_rd_ff[DepthW-1:0];
            up_ff   <= b_rd_ff[2*DepthW-1:DepthW];
            down_ff <= b_cmd_ff.depth;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_cmd_ff <= q_cmd;
         b_rd_ff  <= line_mem[q_cmd.col];
      end
      if (done) begin
         line_mem[b_cmd_ff.col] <= {b_rd_ff[DepthW-1:0], b_cmd_ff.depth};
      end
      fl_rd_ff <= line_mem[ptr_in][DepthW-1:0];
      if (emit_now && out_space) begin
         rsp_depth_ff <= res_depth;
         rsp_cav_ff   <= res_cav;
         rsp_last_ff  <= res_last;
         rsp_eof_ff   <= res_eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_cav_ff, rsp_depth_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_eof_ff;

endmodule

// File: rtl/clmm_checker.sv
`timescale 1ns / 1ps
// port-level checks on the result channel of the marker, bound to the top level
// depends on cavity_local_max_marker_top

module clmm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // end of frame closes the run of the last item
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without last of run");

   // the final cell is on the border and never a cavity
   a_eof_border: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[4])
      else $error("cavity flagged on last cell");

   // a strict maximum cannot have depth zero
   a_cav_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3:0] != 4'd0)
      else $error("cavity with zero depth");

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule

bind cavity_local_max_marker_top clmm_checker u_clmm_checker (.*);

// File: verif/cavity_local_max_marker_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for cavity_local_max_marker_top: streams depth maps, predicts
// every marked cell and compares each result item under random idling and back-pressure
// depends on clmm_pkg and the rtl of cavity_local_max_marker_top

module cavity_local_max_marker_top_tb;
   import clmm_pkg::*;

   localparam int HistDepth   = 2 * MaxSize + 2;
   localparam int CycleLimit  = 300000;
   localparam int RandomCells = 36;

   typedef struct {
      logic [DepthW-1:0] depth;
      logic              cavity;
      logic              run_end;
      logic              frame_end;
   } marked_cell_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       csr_tvalid = 1'b0;
   logic       csr_tready;
   logic [7:0] csr_tdata  = 8'd0;   // grid_size [5:0]
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // depth_digit [3:0]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // cell_depth [3:0], is_cavity [4]
   logic       rsp_tlast;           // last_of_run
   logic       rsp_tuser;           // end_of_frame

   // predictor state
   logic [DepthW-1:0] depth_hist [HistDepth];
   int unsigned       row_pos;
   int unsigned       col_pos;
   logic [GridW-1:0]  side_reg;
   marked_cell_type   pending_cells [$];

   int unsigned mismatch_cnt = 0;
   int unsigned cycle_cnt    = 0;
   int          hold_req     = 0;
   bit          src_idle_on  = 1'b1;
   bit          sink_idle_on = 1'b1;

   cavity_local_max_marker_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned eff_side();
      int unsigned n;
      n = side_reg;
      if (n < 1) n = 1;
      if (n > MaxSize) n = MaxSize;
      return n;
   endfunction

   function automatic marked_cell_type grade_cell(int unsigned c, int unsigned n,
                                                  bit run_end, bit frame_end);
      marked_cell_type m;
      int unsigned  r;
      int unsigned  cl;
      logic [DepthW-1:0] d;
      r  = c / n;
      cl = c % n;
      d  = depth_hist[c % HistDepth];
      m.depth     = d;
      m.cavity    = 1'b0;
      m.run_end   = run_end;
      m.frame_end = frame_end;
      // interior only: all four neighbours must be strictly shallower
      if (r >= 1 && r + 2 <= n && cl >= 1 && cl + 2 <= n) begin
         m.cavity = (d > depth_hist[(c - n) % HistDepth]) &&
                    (d > depth_hist[(c + n) % HistDepth]) &&
                    (d > depth_hist[(c - 1) % HistDepth]) &&
                    (d > depth_hist[(c + 1) % HistDepth]);
      end
      return m;
   endfunction

   function automatic void absorb_depth(logic [DepthW-1:0] d);
      int unsigned n;
      int unsigned k;
      int unsigned last;
      int unsigned first;
      n = eff_side();
      if (row_pos >= n || col_pos >= n) begin
         row_pos = 0;
         col_pos = 0;
      end
      k = row_pos * n + col_pos;
      depth_hist[k % HistDepth] = d;
      last = n * n - 1;
      if (k == last) begin
         // final cell flushes everything still held back
         first = (k >= n + 1) ? k - n - 1 : 0;
         for (int unsigned c = first; c <= k; c++)
            pending_cells.push_back(grade_cell(c, n, c == k, c == k));
         row_pos = 0;
         col_pos = 0;
         return;
      end
      if (k >= n + 1)
         pending_cells.push_back(grade_cell(k - n - 1, n, 1'b1, 1'b0));
      col_pos++;
      if (col_pos >= n) begin
         col_pos = 0;
         row_pos++;
      end
   endfunction

   // ---------------------------------------------------------------- scoreboard

   always @(posedge clock) begin
      marked_cell_type want;
      if (reset) begin
         foreach (depth_hist[i]) depth_hist[i] = '0;
         row_pos  = 0;
         col_pos  = 0;
         side_reg = GridW'(MaxSize);
         pending_cells.delete();
      end else begin
         if (csr_tvalid && csr_tready) begin
            side_reg = csr_tdata[GridW-1:0];
            row_pos  = 0;
            col_pos  = 0;
         end
         if (req_tvalid && req_tready)
            absorb_depth(req_tdata[DepthW-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_cells.size() == 0) begin
               $error("unexpected result item: depth %0d cavity %0b",
                      rsp_tdata[3:0], rsp_tdata[4]);
               mismatch_cnt++;
            end else begin
               want = pending_cells.pop_front();
               if (rsp_tdata[3:0] !== want.depth) begin
                  $error("cell_depth: expected %0d, got %0d", want.depth, rsp_tdata[3:0]);
                  mismatch_cnt++;
               end
               if (rsp_tdata[4] !== want.cavity) begin
                  $error("is_cavity: expected %0b, got %0b", want.cavity, rsp_tdata[4]);
                  mismatch_cnt++;
               end
               if (rsp_tlast !== want.run_end) begin
                  $error("last_of_run: expected %0b, got %0b", want.run_end, rsp_tlast);
                  mismatch_cnt++;
               end
               if (rsp_tuser !== want.frame_end) begin
                  $error("end_of_frame: expected %0b, got %0b", want.frame_end, rsp_tuser);
                  mismatch_cnt++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- result sink

   initial begin : sink_ctl
      int span;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            // long hold-off so the block fills and stalls its input
            span     = hold_req;
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (span - 1) @(posedge clock);
         end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
            span = $urandom_range(1, 10);
            rsp_tready <= 1'b0;
            repeat (span - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_depth(input logic [DepthW-1:0] d);
      int unsigned gap;
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {4'd0, d};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(input int unsigned cells);
      repeat (cells) send_depth(DepthW'($urandom_range(0, 15)));
   endtask

   // wait for every expected item, then let the pipeline run dry
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_side(input logic [GridW-1:0] v);
      settle();
      csr_tdata  <= {2'd0, v};
      csr_tvalid <= 1'b1;
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_size_frame();
      // first rows of a map at the side length left by reset
      send_frame(2 * MaxSize + 6);
   endtask

   task automatic test_tiny_maps();
      write_side(6'd0);
      send_depth(4'd15);
      send_depth(4'd0);
      write_side(6'd1);
      send_depth(4'd9);
      write_side(6'd2);
      send_depth(4'd15);
      send_depth(4'd0);
      send_depth(4'd9);
      send_depth(4'd8);
   endtask

   task automatic test_cavity_shapes();
      logic [DepthW-1:0] peak [9] = '{0, 1, 0, 2, 15, 3, 0, 4, 0};
      logic [DepthW-1:0] tie  [9] = '{0, 0, 0, 0, 8, 8, 0, 0, 0};
      write_side(6'd3);
      foreach (peak[i]) send_depth(peak[i]);
      foreach (tie[i]) send_depth(tie[i]);
   endtask

   task automatic test_abandoned_frames();
      repeat (5) send_depth(4'd7);
      write_side(6'd63);
      send_depth(4'd0);
      send_depth(4'd15);
      send_depth(4'd6);
      write_side(6'd3);
   endtask

   task automatic test_random_frames();
      int unsigned sent;
      int unsigned pick;
      int unsigned n;
      int unsigned cells;
      int unsigned frames;
      logic [GridW-1:0] v;
      sent = 0;
      while (sent < RandomCells) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)      v = GridW'($urandom_range(3, 6));
         else if (pick < 7) v = GridW'($urandom_range(1, 2));
         else if (pick < 9) v = GridW'($urandom_range(7, 12));
         else               v = GridW'($urandom_range(0, 63));
         write_side(v);
         n = eff_side();
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames && sent < RandomCells; f++) begin
            // broken frame: cut short, next write starts afresh
            if (n * n > 1 && (n > 12 || sent + n * n > RandomCells ||
                              $urandom_range(0, 6) == 0)) begin
               cells = $urandom_range(1, (n * n - 1 < 20) ? n * n - 1 : 20);
               send_frame(cells);
               sent += cells;
               break;
            end
            send_frame(n * n);
            sent += n * n;
         end
      end
   endtask

   task automatic test_output_backpressure();
      write_side(6'd5);
      src_idle_on = 1'b0;
      hold_req    = 120;
      send_frame(50);
   endtask

   task automatic test_streaming_finish();
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      write_side(6'd4);
      send_frame(16);
      write_side(6'd3);
      send_frame(9);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size_frame();
      test_tiny_maps();
      test_cavity_shapes();
      test_abandoned_frames();
      test_random_frames();
      test_output_backpressure();
      test_streaming_finish();
      settle();
      if (mismatch_cnt == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: cavity_local_max_marker_top.f
rtl/clmm_pkg.sv
rtl/clmm_front.sv
rtl/clmm_queue.sv
rtl/clmm_back.sv
rtl/cavity_local_max_marker_top.sv
rtl/clmm_checker.sv
verif/cavity_local_max_marker_top_tb.sv
